@@ rtl/lzw_hash_dictionary_compressor_macros.svh @@
// Assertion macros for the LZW hashed-dictionary compressor checker.
// Needs nothing else; included by the checker file.
`ifndef LZW_HASH_DICTIONARY_COMPRESSOR_MACROS_SVH
`define LZW_HASH_DICTIONARY_COMPRESSOR_MACROS_SVH

// implication checked on every rising edge outside reset
`define LZWHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LZWHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lzwhd_pkg.sv @@
// Shared types and constants of the LZW hashed-dictionary compressor.
// No dependencies.
package lzwhd_pkg;

    localparam int DICT_SIZE_DEF = 16384;
    localparam int MAX_BLOCK_DEF = 8192;

    localparam logic [7:0]  HDR_BYTE     = 8'd2;
    localparam logic [3:0]  HDR_WIDTH    = 4'd8;
    localparam logic [3:0]  FIRST_CW     = 4'd9;
    localparam int          FIRST_LIMIT  = 512;
    localparam int          FIRST_CODE   = 256;
    localparam logic [1:0]  WIDEN_STEPS  = 2'd3;
    localparam int          EPOCH_W      = 4;
    localparam int          PK_CODE_W    = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [PK_CODE_W-1:0] code;
        logic [3:0]           width;
        logic                 last;
        logic                 konst;
        logic                 too_long;
    } t_pk_cmd;

endpackage

@@ rtl/lzw_hash_dictionary_compressor.sv @@
// LZW block compressor with hashed dictionary and variable-width codes.
// Top level; depends on lzwhd_pkg, lzwhd_front, lzwhd_engine, lzwhd_packer.
//
// Usage: one source byte per word on s_axis (tdata = byte, tlast = last byte
// of the block). Compressed words leave on m_axis: tdata[7:0] is the byte,
// tdata[23:8] the block's total byte count (header included) on the word
// with tlast, tuser[0] marks a block of identical bytes (with tlast) and
// tuser[1] a block longer than MAX_BLOCK. Each block begins with header 2.
// Flow: a source byte waits in the input queue, then the engine probes the
// dictionary until it finds a match, a free slot or has probed the whole
// table. The single-port dictionary memory is read then compared once per
// probe (S_READ then S_CMP). Output bytes drain at one per cycle while the
// receiver is ready.
// Reset: a clearing sweep runs through every entry of the dictionary;
// the same sweep follows every 15th block when the block tag wraps. Source
// words are queued (two deep) but not processed during the sweep.
// A stalled receiver holds the output register; the engine then waits and
// the input queue fills and drops tready.
// DICT_SIZE must be a power of two.
module lzw_hash_dictionary_compressor
    import lzwhd_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] total_bytes
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] block_constant, [1] block_too_long
);

    logic    item_valid;
    t_item   item;
    logic    item_pop;
    logic    cmd_valid;
    t_pk_cmd cmd;
    logic    cmd_ready;

    lzwhd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_pop    (item_pop)
    );

    lzwhd_engine #(
        .DICT_SIZE (DICT_SIZE),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    lzwhd_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_ready   (cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ rtl/lzwhd_front.sv @@
// Input side: takes source words and holds them in a two-entry queue.
// Depends on lzwhd_pkg.
module lzwhd_front
    import lzwhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_item_pop
);

    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_cnt != 2'd0);
    assign pop           = i_item_pop && o_item_valid;
    assign o_item        = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp].data <= s_axis_tdata;
            r_buf[r_wp].last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/lzwhd_engine.sv @@
// Dictionary engine: hashed lookup with linear probing, insertion, code widths.
// Depends on lzwhd_pkg; feeds code commands to lzwhd_packer.
module lzwhd_engine
    import lzwhd_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    output logic    o_cmd_valid,
    output t_pk_cmd o_cmd,
    input  logic    i_cmd_ready
);

    localparam int AW     = $clog2(DICT_SIZE);
    localparam int CODE_W = $clog2(MAX_BLOCK + FIRST_CODE + 1);
    localparam int LIM_W  = CODE_W + 1;
    localparam int SEEN_W = $clog2(MAX_BLOCK + 2);
    localparam int WORD_W = EPOCH_W + CODE_W + 8 + CODE_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_HDR   = 3'd4;
    localparam logic [2:0] S_MISS  = 3'd5;
    localparam logic [2:0] S_LAST  = 3'd6;

    logic [WORD_W-1:0] mem [DICT_SIZE];

    logic [2:0]         r_state;
    logic [7:0]         r_d;
    logic               r_end;
    logic [CODE_W-1:0]  r_prefix;
    logic [CODE_W-1:0]  r_nfc;
    logic [LIM_W-1:0]   r_limit;
    logic [3:0]         r_cw;
    logic [1:0]         r_wd;
    logic               r_first;
    logic [7:0]         r_fbyte;
    logic               r_same;
    logic [SEEN_W-1:0]  r_seen;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_probes;
    logic [WORD_W-1:0]  r_q;

    logic               mem_we;
    logic [WORD_W-1:0]  mem_wd;
    logic [EPOCH_W-1:0] q_epoch;
    logic [CODE_W-1:0]  q_prefix;
    logic [7:0]         q_byte;
    logic [CODE_W-1:0]  q_code;
    logic               ent_valid;
    logic               ent_match;
    logic               can_insert;
    logic [31:0]        hash;
    logic [CODE_W-1:0]  n_nfc;
    logic [1:0]         n_wd;
    logic               too_long;

    assign {q_epoch, q_prefix, q_byte, q_code} = r_q;
    assign ent_valid  = (q_epoch == r_epoch);
    assign ent_match  = ent_valid && (q_prefix == r_prefix) && (q_byte == r_d);
    assign too_long   = (r_seen > SEEN_W'(MAX_BLOCK));
    assign can_insert = !too_long;
    assign hash = (32'(r_prefix) << 8) ^ 32'(i_item.data) ^ (32'(r_prefix) >> 6);
    assign n_nfc = r_nfc + CODE_W'(1);
    assign n_wd  = (LIM_W'(n_nfc) == r_limit) ? WIDEN_STEPS : r_wd;

    always_comb begin
        mem_we = 1'b0;
        mem_wd = {EPOCH_W'(0), CODE_W'(0), 8'd0, CODE_W'(0)};
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_CMP && !ent_valid && can_insert) begin
            mem_we = 1'b1;
            mem_wd = {r_epoch, r_prefix, r_d, r_nfc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_addr] <= mem_wd;
        r_q <= mem[r_addr];
    end

    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid;
    assign o_cmd_valid = (r_state == S_HDR) || (r_state == S_MISS) || (r_state == S_LAST);

    always_comb begin
        o_cmd.code     = PK_CODE_W'(r_prefix);
        o_cmd.width    = r_cw;
        o_cmd.last     = 1'b0;
        o_cmd.konst    = 1'b0;
        o_cmd.too_long = too_long;
        if (r_state == S_HDR) begin
            o_cmd.code  = PK_CODE_W'(HDR_BYTE);
            o_cmd.width = HDR_WIDTH;
        end else if (r_state == S_LAST) begin
            o_cmd.last  = 1'b1;
            o_cmd.konst = r_same;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_probes <= '0;
            r_epoch  <= EPOCH_W'(1);
            r_prefix <= '0;
            r_nfc    <= CODE_W'(FIRST_CODE);
            r_limit  <= LIM_W'(FIRST_LIMIT);
            r_cw     <= FIRST_CW;
            r_wd     <= 2'd0;
            r_first  <= 1'b1;
            r_fbyte  <= 8'd0;
            r_same   <= 1'b1;
            r_seen   <= '0;
            r_d      <= 8'd0;
            r_end    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(DICT_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_d   <= i_item.data;
                        r_end <= i_item.last;
                        if (r_first) begin
                            r_first  <= 1'b0;
                            r_fbyte  <= i_item.data;
                            r_same   <= 1'b1;
                            r_seen   <= SEEN_W'(1);
                            r_prefix <= CODE_W'(i_item.data);
                            r_state  <= S_HDR;
                        end else begin
                            if (r_seen <= SEEN_W'(MAX_BLOCK)) r_seen <= r_seen + SEEN_W'(1);
                            if (i_item.data != r_fbyte) r_same <= 1'b0;
                            r_addr   <= hash[AW-1:0];
                            r_probes <= '0;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!ent_valid) begin
                        if (can_insert) begin
                            r_nfc <= n_nfc;
                            r_wd  <= n_wd;
                            if (n_wd != 2'd0) begin
                                r_wd <= n_wd - 2'd1;
                                if (n_wd == 2'd1) begin
                                    r_limit <= r_limit << 1;
                                    r_cw    <= r_cw + 4'd1;
                                end
                            end
                        end
                        r_state <= S_MISS;
                    end else if (ent_match) begin
                        r_prefix <= q_code;
                        r_state  <= r_end ? S_LAST : S_IDLE;
                    end else if (r_probes == AW'(DICT_SIZE - 1)) begin
                        r_state <= S_MISS;
                    end else begin
                        r_addr   <= r_addr + AW'(1);
                        r_probes <= r_probes + AW'(1);
                        r_state  <= S_READ;
                    end
                end
                S_HDR: begin
                    if (i_cmd_ready) r_state <= r_end ? S_LAST : S_IDLE;
                end
                S_MISS: begin
                    if (i_cmd_ready) begin
                        r_prefix <= CODE_W'(r_d);
                        r_state  <= r_end ? S_LAST : S_IDLE;
                    end
                end
                S_LAST: begin
                    if (i_cmd_ready) begin
                        // start a fresh block; a wrapped epoch needs a clearing sweep
                        r_prefix <= '0;
                        r_nfc    <= CODE_W'(FIRST_CODE);
                        r_limit  <= LIM_W'(FIRST_LIMIT);
                        r_cw     <= FIRST_CW;
                        r_wd     <= 2'd0;
                        r_first  <= 1'b1;
                        r_fbyte  <= 8'd0;
                        r_same   <= 1'b1;
                        r_seen   <= '0;
                        if (r_epoch == {EPOCH_W{1'b1}}) begin
                            r_epoch <= EPOCH_W'(1);
                            r_addr  <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_epoch <= r_epoch + EPOCH_W'(1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/lzwhd_packer.sv @@
// Bit packer: LSB-first code packing, byte count and the output register.
// Depends on lzwhd_pkg.
module lzwhd_packer
    import lzwhd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_pk_cmd     i_cmd,
    output logic        o_cmd_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [23:8] total_bytes
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser   // [0] block_constant, [1] block_too_long
);

    logic        r_busy;
    logic [23:0] r_acc;
    logic [4:0]  r_fill;
    logic        r_last;
    logic        r_konst;
    logic        r_tl;
    logic [15:0] r_count;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic [15:0] r_ototal;
    logic        r_olast;
    logic        r_okonst;
    logic        r_otl;

    logic        take;
    logic        out_free;
    logic        emit;
    logic [4:0]  rem;
    logic        emit_last;
    logic        done;
    logic [15:0] mask;
    logic [15:0] n_count;

    assign o_cmd_ready = !r_busy;
    assign take        = i_cmd_valid && !r_busy;
    assign out_free    = !r_ovalid || m_axis_tready;
    assign emit        = r_busy && out_free;
    assign rem         = (r_fill >= 5'd8) ? (r_fill - 5'd8) : 5'd0;
    assign emit_last   = r_last && (rem == 5'd0);
    assign done        = (rem < 5'd8) && (!r_last || rem == 5'd0);
    assign mask        = (16'd1 << i_cmd.width) - 16'd1;
    assign n_count     = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_acc    <= 24'd0;
            r_fill   <= 5'd0;
            r_last   <= 1'b0;
            r_konst  <= 1'b0;
            r_tl     <= 1'b0;
            r_count  <= 16'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_acc   <= {16'd0, r_acc[7:0]} | (24'(i_cmd.code & mask) << r_fill);
                r_fill  <= r_fill + {1'b0, i_cmd.width};
                r_last  <= i_cmd.last;
                r_konst <= i_cmd.konst;
                r_tl    <= i_cmd.too_long;
                r_busy  <= 1'b1;
            end
            if (out_free) r_ovalid <= emit;
            if (emit) begin
                r_busy <= !done;
                if (emit_last) begin
                    r_acc   <= 24'd0;
                    r_fill  <= 5'd0;
                    r_count <= 16'd0;
                end else begin
                    r_acc   <= r_acc >> 8;
                    r_fill  <= rem;
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte  <= r_acc[7:0];
            r_olast  <= emit_last;
            r_ototal <= emit_last ? n_count : 16'd0;
            r_okonst <= emit_last && r_konst;
            r_otl    <= r_tl;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ototal, r_obyte};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_otl, r_okonst};

endmodule

@@ rtl/lzwhd_checker.sv @@
// Port-level checker for the compressor, bound to the top level.
// Depends on lzw_hash_dictionary_compressor_macros.svh.
`include "lzw_hash_dictionary_compressor_macros.svh"

module lzwhd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    `LZWHD_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")
    `LZWHD_ASSERT_IMP(a_total_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[23:8] == 16'd0 && !m_axis_tuser[0], "count or constant flag set before last word")
    `LZWHD_ASSERT_IMP(a_total_min, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[23:8] >= 16'd3, "block shorter than header plus one code")
    `LZWHD_ASSERT_NXT(a_header, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || m_axis_tdata[7:0] == 8'd2, "block does not open with header")

endmodule

bind lzw_hash_dictionary_compressor lzwhd_checker u_lzwhd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/lzw_hash_dictionary_compressor_tb.sv @@
// Self-checking bench for lzw_hash_dictionary_compressor: source blocks in, compressed words out.
// Depends on lzwhd_pkg and the compressor RTL; a class tracks the LZW coder and checks each word.
module lzw_hash_dictionary_compressor_tb;
    import lzwhd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DSIZE = DICT_SIZE_DEF;
    localparam int BLK_MAX = MAX_BLOCK_DEF;

    typedef struct {
        bit [7:0]  out_byte;
        bit        out_last;
        bit [15:0] total_bytes;
        bit        block_constant;
        bit        block_too_long;
    } lzw_word_t;

    class lzw_coder_tracker;
        lzw_word_t   expected_words[$];
        int          fail_count;
        bit          slot_used[DSIZE];
        bit [13:0]   slot_prefix[DSIZE];
        bit [7:0]    slot_byte[DSIZE];
        bit [13:0]   slot_code[DSIZE];
        bit [31:0]   prefix, acc, fill, free_code, limit, cwidth, widen, emitted;
        bit          first_pending, same;
        bit [7:0]    first_byte;
        bit [31:0]   seen;

        function void clear_block();
            foreach (slot_used[i]) slot_used[i] = 0;
            prefix = 0; acc = 0; fill = 0; free_code = FIRST_CODE;
            limit = FIRST_LIMIT; cwidth = FIRST_CW; widen = 0; emitted = 0;
            first_pending = 1; first_byte = 0; same = 1; seen = 0;
        endfunction

        function void push_byte(bit [7:0] b);
            lzw_word_t w;
            w.out_byte = b;
            w.out_last = 0;
            w.total_bytes = 0;
            w.block_constant = 0;
            w.block_too_long = (seen > BLK_MAX);
            if (emitted < 65535) emitted++;
            expected_words.push_back(w);
        endfunction

        function void push_code(bit [31:0] code);
            bit [31:0] w;
            bit [31:0] a;
            bit [31:0] f;
            w = cwidth & 15;
            a = (acc & 8'hFF) | ((code & ((32'd1 << w) - 1)) << fill);
            f = fill + w;
            while (f >= 8) begin
                push_byte(a[7:0]);
                a = a >> 8;
                f -= 8;
            end
            acc = a & 8'hFF;
            fill = f;
        endfunction

        // work out every word caused by one accepted source byte
        function void note_source(bit [7:0] d, bit blk_end);
            bit [31:0] hv;
            bit [31:0] probes;
            bit found;
            bit free_slot;
            if (first_pending) begin
                first_pending = 0;
                first_byte = d;
                same = 1;
                seen = 1;
                prefix = d;
                push_byte(HDR_BYTE);
            end else begin
                probes = 0; found = 0; free_slot = 0;
                if (seen <= BLK_MAX) seen++;
                if (d != first_byte) same = 0;
                hv = ((prefix << 8) ^ d ^ (prefix >> 6)) % DSIZE;
                while (probes < DSIZE) begin
                    if (!slot_used[hv]) begin
                        free_slot = 1;
                        break;
                    end
                    if (slot_prefix[hv] == prefix[13:0] && slot_byte[hv] == d) begin
                        found = 1;
                        break;
                    end
                    hv = (hv + 1) % DSIZE;
                    probes++;
                end
                if (found) begin
                    prefix = slot_code[hv];
                end else begin
                    if (free_slot && seen <= BLK_MAX) begin
                        slot_used[hv] = 1;
                        slot_prefix[hv] = prefix[13:0];
                        slot_byte[hv] = d;
                        slot_code[hv] = free_code[13:0];
                        free_code++;
                        if (free_code == limit) widen = WIDEN_STEPS;
                        if (widen > 0) begin
                            widen--;
                            if (widen == 0) begin
                                limit = limit << 1;
                                cwidth++;
                            end
                        end
                    end
                    push_code(prefix);
                    prefix = d;
                end
            end
            if (blk_end) begin
                push_code(prefix);
                if (fill > 0) begin
                    push_byte(acc[7:0]);
                    acc = 0;
                    fill = 0;
                end
                expected_words[$].out_last = 1;
                expected_words[$].total_bytes = emitted[15:0];
                expected_words[$].block_constant = same;
                clear_block();
            end
        endfunction

        function void check_word(lzw_word_t got);
            lzw_word_t e;
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte %0h", got.out_byte);
                fail_count++;
                return;
            end
            e = expected_words.pop_front();
            if (got.out_byte != e.out_byte) begin
                $error("out_byte expected %0h actual %0h", e.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.out_last != e.out_last) begin
                $error("out_last expected %0d actual %0d", e.out_last, got.out_last);
                fail_count++;
            end
            if (got.total_bytes != e.total_bytes) begin
                $error("total_bytes expected %0d actual %0d", e.total_bytes, got.total_bytes);
                fail_count++;
            end
            if (got.block_constant != e.block_constant) begin
                $error("block_constant expected %0d actual %0d", e.block_constant,
                       got.block_constant);
                fail_count++;
            end
            if (got.block_too_long != e.block_too_long) begin
                $error("block_too_long expected %0d actual %0d", e.block_too_long,
                       got.block_too_long);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;   // [7:0] data_byte
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;       // [7:0] out_byte, [23:8] total_bytes
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;       // [0] block_constant, [1] block_too_long

    lzw_coder_tracker coder;
    int send_idle_pct = 38;
    int recv_idle_pct = 87;
    int items_sent = 0;

    lzw_hash_dictionary_compressor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("lzw_hash_dictionary_compressor verification failed");
        $finish;
    end

    task automatic send_source(bit [7:0] d, bit blk_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        s_axis_tlast <= blk_end;
        do @(posedge i_clk); while (!s_axis_tready);
        coder.note_source(d, blk_end);
        items_sent++;
    endtask

    // alphabet: 0 full byte range, otherwise a narrow set so prefixes grow
    task automatic send_block(int len, int alphabet);
        bit [7:0] base;
        base = 8'($urandom_range(255));
        for (int i = 0; i < len; i++) begin
            if (alphabet == 0) send_source(8'($urandom_range(255)), i == len - 1);
            else send_source(8'(base + $urandom_range(alphabet - 1)), i == len - 1);
        end
    endtask

    task automatic send_random_blocks(int until_count);
        while (items_sent < until_count)
            send_block($urandom_range(1, 40), ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4));
    endtask

    // receiver: check on accept, then pick the next ready
    initial begin
        lzw_word_t got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.out_byte = m_axis_tdata[7:0];
                got.total_bytes = m_axis_tdata[23:8];
                got.out_last = m_axis_tlast;
                got.block_constant = m_axis_tuser[0];
                got.block_too_long = m_axis_tuser[1];
                coder.check_word(got);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int waited;
        coder = new();
        coder.clear_block();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // single-byte blocks at both extremes, a constant block, a repeating pattern, a two-byte block
        send_source(8'h00, 1);
        send_source(8'hFF, 1);
        for (int i = 0; i < 8; i++) send_source(8'hAA, i == 7);
        for (int i = 0; i < 12; i++) send_source((i % 2) ? 8'h61 : 8'h62, i == 11);
        send_source(8'h55, 0);
        send_source(8'h55, 1);

        send_random_blocks(100);
        send_idle_pct = 87;
        recv_idle_pct = 38;
        send_random_blocks(190);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_blocks(280);
        s_axis_tvalid <= 0;

        waited = 0;
        while (coder.expected_words.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (coder.fail_count == 0 && coder.expected_words.size() == 0)
            $display("lzw_hash_dictionary_compressor verification clean");
        else
            $display("lzw_hash_dictionary_compressor verification failed");
        $finish;
    end
endmodule
